// File: sv/dataflash_command_sequencer_unit_assert.svh
// Assertion macros used by the sequencer's port checker
`ifndef DATAFLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define DATAFLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define DCS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define DCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dcs_pkg.sv
// Types, codes and helpers for the dataflash command sequencer
`default_nettype none

package dcs_pkg;

  typedef enum logic [1:0] {
    OP_REQ   = 2'd0,
    OP_REPLY = 2'd1,
    OP_DATA  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_ID     = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_READ   = 2'd2,
    CMD_PROG   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    K_SPI  = 2'd0,
    K_HOST = 2'd1,
    K_REL  = 2'd2,
    K_DONE = 2'd3
  } kind_e;

  localparam logic [15:0] MAX_PROGRAM_BYTES = 16'd528;

  localparam logic [7:0] FL_READ_ID     = 8'h9F;
  localparam logic [7:0] FL_STATUS      = 8'hD7;
  localparam logic [7:0] FL_READ_FAST   = 8'h0B;
  localparam logic [7:0] FL_BUF1_WRITE  = 8'h84;
  localparam logic [7:0] FL_BUF1_COMMIT = 8'h83;
  localparam logic [7:0] FL_ZERO        = 8'h00;
  localparam logic [7:0] FL_FILL        = 8'hFF;

  localparam int unsigned BUNDLE_SLOTS = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  command;
    logic [11:0] page;
    logic [9:0]  byte_offset;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic [7:0] host_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic [7:0] host_byte;
  } res_t;

  // results caused by one accepted transaction
  typedef struct packed {
    logic [1:0]                  cnt;
    res_t [BUNDLE_SLOTS-1:0]     ent;
  } bundle_t;

  function automatic bundle_t add_res(bundle_t b, kind_e k, logic [7:0] v);
    bundle_t r;
    r = b;
    r.ent[b.cnt].kind      = k;
    r.ent[b.cnt].spi_byte  = (k == K_SPI)  ? v : 8'h00;
    r.ent[b.cnt].host_byte = (k == K_HOST) ? v : 8'h00;
    r.cnt = b.cnt + 2'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/dcs_front.sv
// Front end: accepts transactions and runs the command phase machine
`default_nettype none

module dcs_front
  import dcs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output bundle_t       bundle_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID, PH_STAT, PH_RD_POLL, PH_RD_ADDR, PH_RD_DATA,
    PH_PG_STAT, PH_PG_HDR, PH_PG_WAIT, PH_PG_DATA, PH_PG_COMMIT, PH_PG_POLL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [11:0] page_q, page_d;
  logic [9:0]  offset_q, offset_d;
  logic [15:0] rem_q, rem_d;
  logic [2:0]  step_q, step_d;
  logic        binary_q, binary_d;

  logic [23:0] rd_addr;
  logic [7:0]  rd_addr_byte;
  logic [7:0]  commit_byte;
  logic [15:0] rem_dec;
  logic [7:0]  b;
  bundle_t     bnd;

  assign b       = item_i.data_byte;
  assign rem_dec = rem_q - 16'd1;
  assign rd_addr = binary_q ? {3'b000, page_q, offset_q[8:0]} : {2'b00, page_q, offset_q};

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    rd_addr_byte = rd_addr[23:16];
      2'd1:    rd_addr_byte = rd_addr[15:8];
      default: rd_addr_byte = rd_addr[7:0];
    endcase
    unique case (step_q[1:0])
      2'd0:    commit_byte = binary_q ? {3'b000, page_q[11:7]} : {2'b00, page_q[11:6]};
      2'd1:    commit_byte = binary_q ? {page_q[6:0], 1'b0} : {page_q[5:0], 2'b00};
      default: commit_byte = FL_ZERO;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    page_d   = page_q;
    offset_d = offset_q;
    rem_d    = rem_q;
    step_d   = step_q;
    binary_d = binary_q;
    bnd      = '0;
    if (accept_i) begin
      unique case (op_e'(item_i.op))
        OP_REQ: begin
          if (phase_q == PH_IDLE) begin
            page_d   = item_i.page;
            offset_d = item_i.byte_offset;
            rem_d    = item_i.byte_count;
            step_d   = 3'd0;
            unique case (cmd_e'(item_i.command))
              CMD_ID: begin
                bnd     = add_res(bnd, K_SPI, FL_READ_ID);
                phase_d = PH_ID;
              end
              CMD_STATUS: begin
                bnd     = add_res(bnd, K_SPI, FL_STATUS);
                phase_d = PH_STAT;
              end
              CMD_READ: begin
                bnd     = add_res(bnd, K_SPI, FL_STATUS);
                phase_d = PH_RD_POLL;
              end
              CMD_PROG: begin
                if (item_i.byte_count > MAX_PROGRAM_BYTES) rem_d = MAX_PROGRAM_BYTES;
                bnd     = add_res(bnd, K_SPI, FL_STATUS);
                phase_d = PH_PG_STAT;
              end
            endcase
          end
        end
        OP_REPLY: begin
          unique case (phase_q)
            PH_ID: begin
              if (step_q == 3'd1 || step_q == 3'd2) bnd = add_res(bnd, K_HOST, b);
              if (step_q < 3'd6) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = step_q + 3'd1;
              end else begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_DONE, FL_ZERO);
                phase_d = PH_IDLE;
                step_d  = 3'd0;
              end
            end
            PH_STAT: begin
              if (step_q == 3'd0) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = 3'd1;
              end else begin
                bnd     = add_res(bnd, K_HOST, b);
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_DONE, FL_ZERO);
                phase_d = PH_IDLE;
                step_d  = 3'd0;
              end
            end
            PH_RD_POLL: begin
              if (step_q == 3'd0) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = 3'd1;
              end else begin
                bnd    = add_res(bnd, K_REL, FL_ZERO);
                step_d = 3'd0;
                if (b[7]) begin
                  binary_d = b[0];
                  bnd      = add_res(bnd, K_SPI, FL_READ_FAST);
                  phase_d  = PH_RD_ADDR;
                end else begin
                  bnd = add_res(bnd, K_SPI, FL_STATUS);
                end
              end
            end
            PH_RD_ADDR: begin
              if (step_q < 3'd3) begin
                bnd    = add_res(bnd, K_SPI, rd_addr_byte);
                step_d = step_q + 3'd1;
              end else if (step_q == 3'd3) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = 3'd4;
              end else if (rem_q == 16'd0) begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_DONE, FL_ZERO);
                phase_d = PH_IDLE;
                step_d  = 3'd0;
              end else begin
                bnd     = add_res(bnd, K_SPI, FL_FILL);
                phase_d = PH_RD_DATA;
              end
            end
            PH_RD_DATA: begin
              bnd   = add_res(bnd, K_HOST, b);
              rem_d = rem_dec;
              if (rem_dec == 16'd0) begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_DONE, FL_ZERO);
                phase_d = PH_IDLE;
                step_d  = 3'd0;
              end else begin
                bnd = add_res(bnd, K_SPI, FL_FILL);
              end
            end
            PH_PG_STAT: begin
              if (step_q == 3'd0) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = 3'd1;
              end else begin
                binary_d = b[0];
                bnd      = add_res(add_res(bnd, K_REL, FL_ZERO), K_SPI, FL_BUF1_WRITE);
                phase_d  = PH_PG_HDR;
                step_d   = 3'd0;
              end
            end
            PH_PG_HDR: begin
              if (step_q < 3'd3) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = step_q + 3'd1;
              end else if (rem_q == 16'd0) begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_SPI, FL_BUF1_COMMIT);
                phase_d = PH_PG_COMMIT;
                step_d  = 3'd0;
              end else begin
                phase_d = PH_PG_WAIT;
              end
            end
            PH_PG_DATA: begin
              rem_d = rem_dec;
              if (rem_dec == 16'd0) begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_SPI, FL_BUF1_COMMIT);
                phase_d = PH_PG_COMMIT;
                step_d  = 3'd0;
              end else begin
                phase_d = PH_PG_WAIT;
              end
            end
            PH_PG_COMMIT: begin
              if (step_q < 3'd3) begin
                bnd    = add_res(bnd, K_SPI, commit_byte);
                step_d = step_q + 3'd1;
              end else begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_SPI, FL_STATUS);
                phase_d = PH_PG_POLL;
                step_d  = 3'd0;
              end
            end
            PH_PG_POLL: begin
              if (step_q == 3'd0) begin
                bnd    = add_res(bnd, K_SPI, FL_ZERO);
                step_d = 3'd1;
              end else if (b[7]) begin
                bnd     = add_res(add_res(bnd, K_REL, FL_ZERO), K_DONE, FL_ZERO);
                phase_d = PH_IDLE;
                step_d  = 3'd0;
              end else begin
                bnd    = add_res(add_res(bnd, K_REL, FL_ZERO), K_SPI, FL_STATUS);
                step_d = 3'd0;
              end
            end
            default: ;
          endcase
        end
        OP_DATA: begin
          if (phase_q == PH_PG_WAIT) begin
            bnd     = add_res(bnd, K_SPI, b);
            phase_d = PH_PG_DATA;
          end
        end
        default: ;
      endcase
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      page_q   <= '0;
      offset_q <= '0;
      rem_q    <= '0;
      step_q   <= '0;
      binary_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      page_q   <= page_d;
      offset_q <= offset_d;
      rem_q    <= rem_d;
      step_q   <= step_d;
      binary_q <= binary_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/dcs_queue.sv
// Short result-bundle queue between the front and back ends
`default_nettype none

module dcs_queue
  import dcs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  output bundle_t      head_o,
  input  wire logic    pop_i
);

  bundle_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QPTR_W:0]    cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/dcs_back.sv
// Back end: serialises queued bundles into single results on the output register
`default_nettype none

module dcs_back
  import dcs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    head_valid_i,
  input  wire bundle_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_item_t    out_item_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       load;
  logic       is_last;
  res_t       cur;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign cur     = head_i.ent[idx_q];
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= '{kind: cur.kind, spi_byte: cur.spi_byte,
                         host_byte: cur.host_byte, last: is_last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      if (load)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: sv/dataflash_command_sequencer_unit.sv
// Top level of the serial dataflash command sequencer
//
// Input channel (in_valid_i / in_stall_o / in_item_i): host requests, flash
// reply bytes and program payload bytes. One transaction per cycle is taken
// while the internal four-entry bundle queue has room.
// Output channel (out_valid_o / out_stall_i / out_item_o): SPI bytes, host
// bytes, chip-select releases and done marks, one per cycle unless stalled;
// last marks the final result of an input transaction.
// Path: the bundle is registered in the queue, and the output register then
// loads its first result from the queue head. Each input yields zero to
// three results; output throughput is one result per cycle while the
// receiver does not stall, set by the single output register.
// Reset clears the phase machine, queue pointers and output valid flag; the
// block is idle and ready at once. While the receiver stalls, the output
// holds; the queue absorbs up to four further bundles before in_stall_o rises.
`default_nettype none

module dataflash_command_sequencer_unit
  import dcs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  logic    accept;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  bundle_t fr_bundle;
  bundle_t q_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  dcs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .bundle_o (fr_bundle)
  );

  dcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && (fr_bundle.cnt != 2'd0)),
    .push_data_i (fr_bundle),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  dcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

// File: sv/dcs_port_checker.sv
// Port-level checks on the sequencer output, bound to the top level
`default_nettype none
`include "dataflash_command_sequencer_unit_assert.svh"

module dcs_port_checker
  import dcs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  logic [1:0] prev_kind_q;
  logic       out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prev_kind_q <= K_DONE;
    else if (out_acc) prev_kind_q <= out_item_o.kind;
  end

  `DCS_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled output dropped")
  `DCS_ASSERT_NEXT(a_item_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o), "stalled output changed")
  `DCS_ASSERT_IMPLY(a_done_after_rel, clk_i, rst_ni, out_acc && out_item_o.kind == K_DONE, prev_kind_q == K_REL, "done without release")
  `DCS_ASSERT_IMPLY(a_done_last, clk_i, rst_ni, out_acc && out_item_o.kind == K_DONE, out_item_o.last, "done not last")

endmodule

bind dataflash_command_sequencer_unit dcs_port_checker u_port_checker (.*);

`default_nettype wire

// File: verif/dcs_checker.sv
// Checker for the dataflash command sequencer: watches both channels, predicts and compares

module dcs_checker
  import dcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ID, PH_STAT, PH_RD_POLL, PH_RD_ADDR, PH_RD_DATA,
    PH_PG_STAT, PH_PG_HDR, PH_PG_WAIT, PH_PG_DATA, PH_PG_COMMIT, PH_PG_POLL
  } seq_phase_e;

  seq_phase_e  seq_phase;
  logic [11:0] saved_page;
  logic [9:0]  saved_offset;
  logic [15:0] bytes_left;
  logic [2:0]  step;
  logic        binary_pages;

  out_item_t   burst[$];
  out_item_t   pending_results[$];
  out_item_t   want;
  int unsigned failures;

  task automatic report_mismatch(input string msg);
    if (failures < 64) $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic queue_result(input kind_e k, input logic [7:0] v);
    out_item_t r;
    r.kind      = k;
    r.spi_byte  = (k == K_SPI)  ? v : 8'h00;
    r.host_byte = (k == K_HOST) ? v : 8'h00;
    r.last      = 1'b0;
    burst.push_back(r);
  endtask

  task automatic close_sequence();
    queue_result(K_REL, 8'h00);
    queue_result(K_DONE, 8'h00);
    seq_phase = PH_IDLE;
    step      = 3'd0;
  endtask

  task automatic open_commit();
    queue_result(K_REL, 8'h00);
    queue_result(K_SPI, FL_BUF1_COMMIT);
    seq_phase = PH_PG_COMMIT;
    step      = 3'd0;
  endtask

  task automatic predict_transaction(input in_item_t it);
    logic [2:0]  s;
    logic [7:0]  b;
    logic [23:0] addr;
    logic [7:0]  v;
    out_item_t   r;
    s = step;
    b = it.data_byte;
    case (it.op)
      OP_REQ: begin
        if (seq_phase == PH_IDLE) begin
          saved_page   = it.page;
          saved_offset = it.byte_offset;
          bytes_left   = it.byte_count;
          step         = 3'd0;
          case (it.command)
            CMD_ID: begin
              queue_result(K_SPI, FL_READ_ID);
              seq_phase = PH_ID;
            end
            CMD_STATUS: begin
              queue_result(K_SPI, FL_STATUS);
              seq_phase = PH_STAT;
            end
            CMD_READ: begin
              queue_result(K_SPI, FL_STATUS);
              seq_phase = PH_RD_POLL;
            end
            default: begin
              if (bytes_left > MAX_PROGRAM_BYTES) bytes_left = MAX_PROGRAM_BYTES;
              queue_result(K_SPI, FL_STATUS);
              seq_phase = PH_PG_STAT;
            end
          endcase
        end
      end
      OP_REPLY: begin
        case (seq_phase)
          PH_ID: begin
            if (s == 3'd1 || s == 3'd2) queue_result(K_HOST, b);
            if (s < 3'd6) begin
              queue_result(K_SPI, FL_ZERO);
              step = s + 3'd1;
            end else begin
              close_sequence();
            end
          end
          PH_STAT: begin
            if (s == 3'd0) begin
              queue_result(K_SPI, FL_ZERO);
              step = 3'd1;
            end else begin
              queue_result(K_HOST, b);
              close_sequence();
            end
          end
          PH_RD_POLL: begin
            if (s == 3'd0) begin
              queue_result(K_SPI, FL_ZERO);
              step = 3'd1;
            end else begin
              queue_result(K_REL, 8'h00);
              step = 3'd0;
              if (b[7]) begin
                binary_pages = b[0];
                queue_result(K_SPI, FL_READ_FAST);
                seq_phase = PH_RD_ADDR;
              end else begin
                queue_result(K_SPI, FL_STATUS);
              end
            end
          end
          PH_RD_ADDR: begin
            addr = binary_pages ? {3'b000, saved_page, saved_offset[8:0]}
                                : {2'b00, saved_page, saved_offset};
            if (s < 3'd3) begin
              queue_result(K_SPI, 8'(addr >> (16 - 8 * int'(s))));
              step = s + 3'd1;
            end else if (s == 3'd3) begin
              queue_result(K_SPI, FL_ZERO);
              step = 3'd4;
            end else if (bytes_left == 16'd0) begin
              close_sequence();
            end else begin
              queue_result(K_SPI, FL_FILL);
              seq_phase = PH_RD_DATA;
            end
          end
          PH_RD_DATA: begin
            queue_result(K_HOST, b);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) close_sequence();
            else queue_result(K_SPI, FL_FILL);
          end
          PH_PG_STAT: begin
            if (s == 3'd0) begin
              queue_result(K_SPI, FL_ZERO);
              step = 3'd1;
            end else begin
              binary_pages = b[0];
              queue_result(K_REL, 8'h00);
              queue_result(K_SPI, FL_BUF1_WRITE);
              seq_phase = PH_PG_HDR;
              step      = 3'd0;
            end
          end
          PH_PG_HDR: begin
            if (s < 3'd3) begin
              queue_result(K_SPI, FL_ZERO);
              step = s + 3'd1;
            end else if (bytes_left == 16'd0) begin
              open_commit();
            end else begin
              seq_phase = PH_PG_WAIT;
            end
          end
          PH_PG_DATA: begin
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) open_commit();
            else seq_phase = PH_PG_WAIT;
          end
          PH_PG_COMMIT: begin
            if (s < 3'd3) begin
              if (s == 3'd0) v = binary_pages ? 8'(saved_page >> 7) : 8'(saved_page >> 6);
              else if (s == 3'd1) v = binary_pages ? {saved_page[6:0], 1'b0}
                                                   : {saved_page[5:0], 2'b00};
              else v = 8'h00;
              queue_result(K_SPI, v);
              step = s + 3'd1;
            end else begin
              queue_result(K_REL, 8'h00);
              queue_result(K_SPI, FL_STATUS);
              seq_phase = PH_PG_POLL;
              step      = 3'd0;
            end
          end
          PH_PG_POLL: begin
            if (s == 3'd0) begin
              queue_result(K_SPI, FL_ZERO);
              step = 3'd1;
            end else if (b[7]) begin
              close_sequence();
            end else begin
              queue_result(K_REL, 8'h00);
              queue_result(K_SPI, FL_STATUS);
              step = 3'd0;
            end
          end
          default: ;
        endcase
      end
      OP_DATA: begin
        if (seq_phase == PH_PG_WAIT) begin
          queue_result(K_SPI, b);
          seq_phase = PH_PG_DATA;
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) begin
      r = burst.pop_back();
      r.last = 1'b1;
      burst.push_back(r);
    end
    foreach (burst[i]) pending_results.push_back(burst[i]);
    burst.delete();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase     = PH_IDLE;
      saved_page    = '0;
      saved_offset  = '0;
      bytes_left    = '0;
      step          = '0;
      binary_pages  = 1'b0;
      failures      = 0;
      pending_results.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_transaction(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, kind %0d spi %h host %h",
                                    out_item_i.kind, out_item_i.spi_byte,
                                    out_item_i.host_byte));
        end else begin
          want = pending_results.pop_front();
          if (out_item_i.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_item_i.kind, want.kind));
          if (out_item_i.spi_byte !== want.spi_byte)
            report_mismatch($sformatf("spi_byte %h, want %h",
                                      out_item_i.spi_byte, want.spi_byte));
          if (out_item_i.host_byte !== want.host_byte)
            report_mismatch($sformatf("host_byte %h, want %h",
                                      out_item_i.host_byte, want.host_byte));
          if (out_item_i.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_item_i.last, want.last));
        end
      end
      fail_count_o  <= failures;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
// Testbench top for the dataflash command sequencer: clock, reset, host and flash-side stimulus, verdict

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {NZ_IDLE, NZ_BUSY, NZ_WAIT} noise_ctx_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned outstanding;
  int          cycle_count = 0;
  int          send_idle   = 0;
  int          recv_idle   = 0;
  int unsigned items_sent  = 0;

  dataflash_command_sequencer_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  dcs_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t random_item(input op_e op);
    in_item_t it;
    it.op          = op;
    it.command     = 2'($urandom);
    it.page        = 12'($urandom);
    it.byte_offset = 10'($urandom);
    it.byte_count  = 16'($urandom);
    it.data_byte   = 8'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] random_length();
    if ($urandom_range(9) == 0) return 16'($urandom_range(40, 9));
    return 16'($urandom_range(6));
  endfunction

  function automatic int random_polls();
    if ($urandom_range(3) == 0) return $urandom_range(2, 1);
    return 0;
  endfunction

  task automatic push_item(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // transactions the block must ignore in its current state
  task automatic maybe_noise(input noise_ctx_e ctx);
    op_e pick;
    if ($urandom_range(5) == 0) begin
      pick = OP_NONE;
      if ($urandom_range(2) != 0) begin
        case (ctx)
          NZ_IDLE: pick = $urandom_range(1) ? OP_REPLY : OP_DATA;
          NZ_BUSY: pick = $urandom_range(1) ? OP_REQ : OP_DATA;
          default: pick = $urandom_range(1) ? OP_REQ : OP_REPLY;
        endcase
      end
      push_item(random_item(pick));
    end
  endtask

  task automatic send_request(input cmd_e cmd, input logic [11:0] page,
                              input logic [9:0] offset, input logic [15:0] count);
    in_item_t it;
    maybe_noise(NZ_IDLE);
    it             = random_item(OP_REQ);
    it.command     = cmd;
    it.page        = page;
    it.byte_offset = offset;
    it.byte_count  = count;
    push_item(it);
    items_sent++;
  endtask

  task automatic flash_reply(input logic [7:0] b);
    in_item_t it;
    maybe_noise(NZ_BUSY);
    it           = random_item(OP_REPLY);
    it.data_byte = b;
    push_item(it);
    items_sent++;
  endtask

  task automatic host_payload(input logic [7:0] b);
    in_item_t it;
    maybe_noise(NZ_WAIT);
    it           = random_item(OP_DATA);
    it.data_byte = b;
    push_item(it);
    items_sent++;
  endtask

  task automatic poll_until_ready(input int busy_polls, input logic page_bit);
    repeat (busy_polls) begin
      flash_reply(8'($urandom));
      flash_reply({1'b0, 7'($urandom)});
    end
    flash_reply(8'($urandom));
    flash_reply({1'b1, 6'($urandom), page_bit});
  endtask

  task automatic run_read_id();
    send_request(CMD_ID, 12'($urandom), 10'($urandom), 16'($urandom));
    repeat (7) flash_reply(8'($urandom));
  endtask

  task automatic run_read_status();
    send_request(CMD_STATUS, 12'($urandom), 10'($urandom), 16'($urandom));
    repeat (2) flash_reply(8'($urandom));
  endtask

  task automatic run_read(input logic [11:0] page, input logic [9:0] offset,
                          input logic [15:0] count, input int busy_polls,
                          input logic page_bit);
    send_request(CMD_READ, page, offset, count);
    poll_until_ready(busy_polls, page_bit);
    repeat (5 + int'(count)) flash_reply(8'($urandom));
  endtask

  task automatic run_program(input logic [11:0] page, input logic [15:0] count,
                             input int busy_polls, input logic page_bit);
    int n;
    n = (count > MAX_PROGRAM_BYTES) ? int'(MAX_PROGRAM_BYTES) : int'(count);
    send_request(CMD_PROG, page, 10'($urandom), count);
    flash_reply(8'($urandom));
    flash_reply({7'($urandom), page_bit});
    repeat (4) flash_reply(8'($urandom));
    repeat (n) begin
      host_payload(8'($urandom));
      flash_reply(8'($urandom));
    end
    repeat (4) flash_reply(8'($urandom));
    poll_until_ready(busy_polls, 1'($urandom));
  endtask

  task automatic run_random_sequences(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) begin
      case ($urandom_range(3))
        0: run_read_id();
        1: run_read_status();
        2: run_read(12'($urandom), 10'($urandom), random_length(), random_polls(),
                    1'($urandom));
        default: run_program(12'($urandom), random_length(), random_polls(),
                             1'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 36;
    recv_idle <= 66;
    push_item(random_item(OP_REPLY));
    push_item(random_item(OP_DATA));
    push_item(random_item(OP_NONE));
    run_read_id();
    run_read_status();
    run_read(12'hFFF, 10'h3FF, 16'd0, 1, 1'b0);
    run_program(12'hFFF, 16'd0, 1, 1'b1);

    send_idle = 66;
    recv_idle <= 36;
    run_read(12'h000, 10'h000, 16'd2, 0, 1'b1);
    run_program(12'hFFF, 16'd1, 0, 1'b0);
    run_random_sequences(8);

    send_idle = 0;
    recv_idle <= 0;
    run_read(12'hFFF, 10'h3FF, 16'd3, 0, 1'b1);
    run_random_sequences(8);

    // oversized program length, left waiting for payload
    send_request(CMD_PROG, 12'h000, 10'h000, 16'hFFFF);
    flash_reply(8'($urandom));
    flash_reply(8'($urandom));
    repeat (4) flash_reply(8'($urandom));
    repeat (2) begin
      host_payload(8'($urandom));
      flash_reply(8'($urandom));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
